FILE: design/ebpd_pkg.sv
`default_nettype none
package ebpd_pkg;

    localparam int NumButtons = 3;
    localparam int HoldW      = 16;
    localparam int DivW       = 8;
    localparam int StepW      = 8;
    localparam int HistW      = 4;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 16;

    localparam logic [HistW-1:0] EdgePattern = 4'b1100;
    localparam logic [HistW-1:0] HistReset   = 4'hf;
    localparam logic [HoldW-1:0] HoldMax     = 16'hffff;

    localparam logic [HoldW-1:0] LongPressReset = 16'd20;
    localparam logic [DivW-1:0]  SampleDivReset = 8'd40;

    localparam logic [CfgIdxW-1:0] RegLongPressTicks    = 2'd0;
    localparam logic [CfgIdxW-1:0] RegButtonSampleDiv   = 2'd1;

    localparam logic [1:0] ActNone = 2'd0;
    localparam logic [1:0] ActInc  = 2'd1;
    localparam logic [1:0] ActDec  = 2'd2;

    typedef struct packed {
        logic                  enc_a_level;
        logic                  enc_b_level;
        logic [NumButtons-1:0] button_levels;
        logic                  count_clear;
    } tick_item_t;

    typedef struct packed {
        logic signed [StepW-1:0] step_count;
        logic [1:0]              enc_action;
        logic [NumButtons-1:0]   short_press;
        logic [NumButtons-1:0]   long_press;
        logic                    buttons_sampled;
    } result_item_t;

    typedef struct packed {
        logic signed [StepW-1:0] step_count;
        logic [1:0]              enc_action;
    } enc_status_t;

    typedef struct packed {
        logic short_evt;
        logic long_evt;
    } lane_evt_t;

endpackage
`default_nettype wire

FILE: design/ebpd_enc_core.sv
`default_nettype none
module ebpd_enc_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  step_en,
    input  wire                  a_level,
    input  wire                  b_level,
    input  wire                  clear,
    output ebpd_pkg::enc_status_t status
);
    import ebpd_pkg::*;

    logic [HistW-1:0]        a_hist_reg, a_hist_next;
    logic [HistW-1:0]        b_hist_reg, b_hist_next;
    logic signed [StepW-1:0] steps_reg, steps_next;
    logic signed [StepW-1:0] steps_base;

    localparam logic signed [StepW-1:0] StepMin = {1'b1, {(StepW-1){1'b0}}};
    localparam logic signed [StepW-1:0] StepMax = {1'b0, {(StepW-1){1'b1}}};

    always_comb
    begin
        a_hist_next = {a_hist_reg[HistW-2:0], a_level};
        b_hist_next = {b_hist_reg[HistW-2:0], b_level};
        steps_base  = clear ? '0 : steps_reg;
        steps_next  = steps_base;
        if (a_hist_next == EdgePattern)
        begin
            if (!b_level && steps_base != StepMin)
                steps_next = steps_base - StepW'(1);
        end
        else if (b_hist_next == EdgePattern)
        begin
            if (!a_level && steps_base != StepMax)
                steps_next = steps_base + StepW'(1);
        end
        status.step_count = steps_next;
        if (steps_next > 0)
            status.enc_action = ActInc;
        else if (steps_next < 0)
            status.enc_action = ActDec;
        else
            status.enc_action = ActNone;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_hist_reg <= HistReset;
            b_hist_reg <= HistReset;
            steps_reg  <= '0;
        end
        else if (step_en)
        begin
            a_hist_reg <= a_hist_next;
            b_hist_reg <= b_hist_next;
            steps_reg  <= steps_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/ebpd_button_lane.sv
`default_nettype none
module ebpd_button_lane (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        sample_en,
    input  wire                        pressed,
    input  wire [ebpd_pkg::HoldW-1:0]  threshold,
    output ebpd_pkg::lane_evt_t        evt
);
    import ebpd_pkg::*;

    logic [HoldW-1:0] hold_reg, hold_next;
    logic             rep_reg, rep_next;
    logic [HoldW-1:0] hold_inc;

    always_comb
    begin
        hold_inc  = (pressed && hold_reg != HoldMax) ? hold_reg + HoldW'(1) : hold_reg;
        hold_next = hold_inc;
        rep_next  = rep_reg;
        evt       = '0;
        if (pressed && hold_inc >= threshold && !rep_reg)
        begin
            evt.long_evt = 1'b1;
            rep_next     = 1'b1;
        end
        else if (!pressed)
        begin
            evt.short_evt = (hold_inc < threshold) && (hold_inc != '0);
            hold_next     = '0;
            rep_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
            rep_reg  <= 1'b0;
        end
        else if (sample_en)
        begin
            hold_reg <= hold_next;
            rep_reg  <= rep_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/ebpd_out_buf.sv
`default_nettype none
module ebpd_out_buf (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   push,
    output logic                                  push_ready,
    input  ebpd_pkg::enc_status_t                 enc_status,
    input  ebpd_pkg::lane_evt_t [ebpd_pkg::NumButtons-1:0] lane_evt,
    input  wire                                   sampled,
    output logic                                  result_valid,
    input  wire                                   result_ready,
    output ebpd_pkg::result_item_t                result
);
    import ebpd_pkg::*;

    result_item_t merged;
    result_item_t out_reg, skid_reg;
    logic         out_v_reg, skid_v_reg;

    // merge lane events with encoder status
    always_comb
    begin
        merged.step_count      = enc_status.step_count;
        merged.enc_action      = enc_status.enc_action;
        merged.buttons_sampled = sampled;
        for (int i = 0; i < NumButtons; i++)
        begin
            merged.short_press[i] = sampled & lane_evt[i].short_evt;
            merged.long_press[i]  = sampled & lane_evt[i].long_evt;
        end
    end

    assign push_ready   = !skid_v_reg;
    assign result_valid = out_v_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || result_ready)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= push;
            end
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || result_ready)
        begin
            if (skid_v_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= merged;
        end
        else if (push)
        begin
            skid_reg <= merged;
        end
    end

endmodule
`default_nettype wire

FILE: design/encoder_and_button_press_decoder_unit.sv
`default_nettype none
// Rotary encoder and push-button decoder. Each tick is decoded in the cycle it
// is accepted and registered as one result; one tick per cycle is sustained while
// the buffer has room. The encoder core and one lane per button evaluate side by
// side and an output stage merges them into a two-entry output buffer, so one more
// tick is taken while a result waits. The tick counter samples the buttons every
// button_sample_divide ticks; long_press_ticks sets the long-press threshold in
// samples. Config writes are always ready and should be issued while idle.
module encoder_and_button_press_decoder_unit (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           tick_valid,
    output logic                          tick_ready,
    input  ebpd_pkg::tick_item_t          tick,
    output logic                          result_valid,
    input  wire                           result_ready,
    output ebpd_pkg::result_item_t        result,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire [ebpd_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire [ebpd_pkg::CfgDataW-1:0]  cfg_data
);
    import ebpd_pkg::*;

    logic [HoldW-1:0] long_press_ticks_reg;
    logic [DivW-1:0]  sample_div_reg;
    logic [DivW-1:0]  tick_div_reg, tick_div_next;
    logic [DivW-1:0]  tick_inc;
    logic             accept;
    logic             sampled;
    enc_status_t      enc_status;
    lane_evt_t [NumButtons-1:0] lane_evt;

    assign cfg_ready = 1'b1;
    assign accept    = tick_valid && tick_ready;

    always_comb
    begin
        tick_inc      = tick_div_reg + DivW'(1);
        sampled       = tick_inc >= sample_div_reg;
        tick_div_next = sampled ? '0 : tick_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_ticks_reg <= LongPressReset;
            sample_div_reg       <= SampleDivReset;
            tick_div_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    RegLongPressTicks:  long_press_ticks_reg <= cfg_data[HoldW-1:0];
                    RegButtonSampleDiv: sample_div_reg       <= cfg_data[DivW-1:0];
                    default: ;
                endcase
            end
            if (accept)
                tick_div_reg <= tick_div_next;
        end
    end

    ebpd_enc_core u_enc (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (accept),
        .a_level (tick.enc_a_level),
        .b_level (tick.enc_b_level),
        .clear   (tick.count_clear),
        .status  (enc_status)
    );

    for (genvar g = 0; g < NumButtons; g++)
    begin : g_lane
        ebpd_button_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .sample_en (accept && sampled),
            .pressed   (!tick.button_levels[g]),
            .threshold (long_press_ticks_reg),
            .evt       (lane_evt[g])
        );
    end

    ebpd_out_buf u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept),
        .push_ready   (tick_ready),
        .enc_status   (enc_status),
        .lane_evt     (lane_evt),
        .sampled      (sampled),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    a_stall_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_ready |-> result_valid)
        else $error("tick stalled with no result pending");

    a_events_need_sample: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.short_press != '0 || result.long_press != '0)
        |-> result.buttons_sampled)
        else $error("button event without a sample");

    a_short_long_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.short_press & result.long_press) == '0)
        else $error("short and long press on one button");

    a_action_matches_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.enc_action == ActInc) == (result.step_count > 0))
                      && ((result.enc_action == ActDec) == (result.step_count < 0)))
        else $error("encoder action disagrees with step count");

endmodule
`default_nettype wire
